>>> hdl/scan_disk_seek_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the SCAN seek scheduler
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef SCAN_DISK_SEEK_SCHEDULER_UNIT_MACROS_SVH
`define SCAN_DISK_SEEK_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SDSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SDSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/sdss_pkg.sv
// ----------------------------------------------------------------------------
// sdss_pkg
// Types and constants shared by the SCAN seek scheduler and its cells.
// ----------------------------------------------------------------------------
package sdss_pkg;

    // Field widths.
    localparam int CYL_BITS   = 16;
    localparam int CFG_BITS   = CYL_BITS + 1;
    localparam int TOTAL_BITS = CYL_BITS + 6;

    // Register reset value: number of cylinders.
    localparam logic [CFG_BITS-1:0] DISK_CYL_RESET = CFG_BITS'(200);

    // Item kinds.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Input beat.
    typedef struct packed {
        logic                req_type;
        logic [CYL_BITS-1:0] request_cylinder;
        logic [CYL_BITS-1:0] head_position;
        logic [CYL_BITS-1:0] previous_position;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic [CYL_BITS-1:0]   visited_cylinder;
        logic [CYL_BITS-1:0]   step_distance;
        logic [TOTAL_BITS-1:0] total_seek;
        logic                  last_visit;
    } out_item_t;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic ins;    // sorted insert of a new request
        logic shift;  // request row moves one cell toward the front
        logic push;   // stack row moves one cell toward the back
        logic pop;    // stack row moves one cell toward the front
    } cell_ctrl_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic                valid;
        logic                gt;
        logic [CYL_BITS-1:0] value;
        logic                s_valid;
        logic [CYL_BITS-1:0] s_value;
    } cell_link_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_SCAN,
        ST_UP_END,
        ST_UP_POP,
        ST_DN_SCAN,
        ST_DN_POP,
        ST_DN_ZERO,
        ST_DN_ASC
    } seq_state_t;

endpackage

>>> hdl/scan_disk_seek_scheduler_unit.sv
// ----------------------------------------------------------------------------
// scan_disk_seek_scheduler_unit
// SCAN (elevator) seek scheduler built on a row of sorting cells.
// ----------------------------------------------------------------------------
// A load beat drops its request into its sorted place in a row of
// MAX_REQUESTS cells, and loads past capacity are taken and dropped.
// A start beat is served from the front cell, one stored request per
// visit plus the end visit in an upward sweep or the visit to cylinder 0
// in a downward sweep, and is held up while m_ready is low. Each
// request below the head in an upward sweep, or below it in a downward sweep,
// takes a silent step moving onto the cell stack before it comes back in
// descending order. An upward sweep adds a silent step where the row runs
// empty and a step for the end visit; a downward sweep adds a silent step
// where the row scan stops, one where the stack runs empty and one for the
// visit to cylinder 0. Each remaining step delivers one visit through the
// single output register. The next beat on s_ is taken once the last visit
// has been placed in that register.
// ----------------------------------------------------------------------------
module scan_disk_seek_scheduler_unit #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sdss_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sdss_pkg::out_item_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sdss_pkg::CFG_BITS-1:0]  cfg_data
);

`include "scan_disk_seek_scheduler_unit_macros.svh"

    localparam int CB = sdss_pkg::CYL_BITS;
    localparam int TB = sdss_pkg::TOTAL_BITS;

    sdss_pkg::seq_state_t  state_reg, state_next;
    sdss_pkg::cell_ctrl_t  ctrl;
    sdss_pkg::cell_link_t  link      [MAX_REQUESTS];
    sdss_pkg::cell_link_t  left_link [MAX_REQUESTS];
    sdss_pkg::cell_link_t  right_link[MAX_REQUESTS];
    sdss_pkg::out_item_t   m_data_reg;

    logic [sdss_pkg::CFG_BITS-1:0] disk_cyl_reg;
    logic [CB-1:0]                 end_cyl;
    logic [CB-1:0]                 end_reg;
    logic [CB-1:0]                 head_reg;
    logic [CB-1:0]                 cur_head_reg;
    logic [TB-1:0]                 total_reg;
    logic                          m_valid_reg;

    logic          out_free;
    logic          start;
    logic [CB-1:0] start_head;
    logic          start_up;
    logic [CB-1:0] front_cyl;
    logic          front_lt;
    logic          front_eq;
    logic          emit;
    logic          emit_last;
    logic [CB-1:0] emit_cyl;
    logic [CB-1:0] step;
    logic [TB:0]   sum;
    logic [TB-1:0] total_sat;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_cyl_reg <= sdss_pkg::DISK_CYL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            disk_cyl_reg <= cfg_data;
        end
    end

    // End cylinder: zero cylinders counts as one, the count saturates at 2^CB.
    always_comb begin
        if (disk_cyl_reg == '0) begin
            end_cyl = '0;
        end else if (disk_cyl_reg[sdss_pkg::CFG_BITS-1] && (|disk_cyl_reg[CB-1:0])) begin
            end_cyl = '1;
        end else begin
            end_cyl = CB'(disk_cyl_reg - sdss_pkg::CFG_BITS'(1));
        end
    end

    // Start beat decode; the direction uses the raw positions.
    assign s_ready    = (state_reg == sdss_pkg::ST_IDLE);
    assign start      = s_valid && s_ready && (s_data.req_type == sdss_pkg::REQ_START);
    assign start_up   = s_data.previous_position < s_data.head_position;
    assign start_head = (s_data.head_position > end_cyl) ? end_cyl : s_data.head_position;

    // Neighbor wiring of the cell row.
    for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
        if (i == 0) begin : g_first
            always_comb begin
                left_link[i]         = '0;
                left_link[i].valid   = 1'b1;
                left_link[i].s_valid = 1'b1;
                left_link[i].s_value = front_cyl;
            end
        end else begin : g_mid
            assign left_link[i] = link[i-1];
        end

        if (i == MAX_REQUESTS - 1) begin : g_last
            assign right_link[i] = '0;
        end else begin : g_inner
            assign right_link[i] = link[i+1];
        end

        sdss_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .ins_cyl  (s_data.request_cylinder),
            .left_in  (left_link[i]),
            .right_in (right_link[i]),
            .link_out (link[i])
        );
    end

    // Front request, clamped to the disk, against the head.
    assign front_cyl = (link[0].value > end_reg) ? end_reg : link[0].value;
    assign front_lt  = link[0].valid && (front_cyl < head_reg);
    assign front_eq  = link[0].valid && (front_cyl == head_reg);

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: next state, cell commands and the visit to emit.
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        emit_cyl   = front_cyl;

        case (state_reg)
            sdss_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.req_type == sdss_pkg::REQ_LOAD) begin
                        ctrl.ins = !link[MAX_REQUESTS-1].valid;
                    end else begin
                        state_next = start_up ? sdss_pkg::ST_UP_SCAN : sdss_pkg::ST_DN_SCAN;
                    end
                end
            end

            // Upward: lower requests go to the stack, the rest are served.
            sdss_pkg::ST_UP_SCAN: begin
                if (!link[0].valid) begin
                    state_next = sdss_pkg::ST_UP_END;
                end else if (front_lt) begin
                    ctrl.shift = 1'b1;
                    ctrl.push  = 1'b1;
                end else if (out_free) begin
                    ctrl.shift = 1'b1;
                    emit       = 1'b1;
                end
            end

            sdss_pkg::ST_UP_END: begin
                emit_cyl  = end_reg;
                emit_last = !link[0].s_valid;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = emit_last ? sdss_pkg::ST_IDLE : sdss_pkg::ST_UP_POP;
                end
            end

            sdss_pkg::ST_UP_POP: begin
                emit_cyl  = link[0].s_value;
                emit_last = !link[1 % MAX_REQUESTS].s_valid;
                if (out_free) begin
                    emit     = 1'b1;
                    ctrl.pop = 1'b1;
                    if (emit_last) begin
                        state_next = sdss_pkg::ST_IDLE;
                    end
                end
            end

            // Downward: lower requests to the stack, equal ones served now.
            sdss_pkg::ST_DN_SCAN: begin
                if (front_lt) begin
                    ctrl.shift = 1'b1;
                    ctrl.push  = 1'b1;
                end else if (front_eq) begin
                    if (out_free) begin
                        ctrl.shift = 1'b1;
                        emit       = 1'b1;
                    end
                end else begin
                    state_next = sdss_pkg::ST_DN_POP;
                end
            end

            sdss_pkg::ST_DN_POP: begin
                emit_cyl = link[0].s_value;
                if (!link[0].s_valid) begin
                    state_next = sdss_pkg::ST_DN_ZERO;
                end else if (out_free) begin
                    emit     = 1'b1;
                    ctrl.pop = 1'b1;
                end
            end

            sdss_pkg::ST_DN_ZERO: begin
                emit_cyl  = '0;
                emit_last = !link[0].valid;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = emit_last ? sdss_pkg::ST_IDLE : sdss_pkg::ST_DN_ASC;
                end
            end

            sdss_pkg::ST_DN_ASC: begin
                emit_last = !link[1 % MAX_REQUESTS].valid;
                if (out_free) begin
                    emit       = 1'b1;
                    ctrl.shift = 1'b1;
                    if (emit_last) begin
                        state_next = sdss_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = sdss_pkg::ST_IDLE;
            end
        endcase
    end

    // Step distance and saturating running total.
    assign step      = (emit_cyl >= cur_head_reg) ? (emit_cyl - cur_head_reg)
                                                  : (cur_head_reg - emit_cyl);
    assign sum       = {1'b0, total_reg} + (TB + 1)'(step);
    assign total_sat = sum[TB] ? '1 : sum[TB-1:0];

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sdss_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Schedule context and the output beat.
    always_ff @(posedge aclk) begin
        if (start) begin
            end_reg      <= end_cyl;
            head_reg     <= start_head;
            cur_head_reg <= start_head;
            total_reg    <= '0;
        end else if (emit) begin
            cur_head_reg <= emit_cyl;
            total_reg    <= total_sat;
        end

        if (emit) begin
            m_data_reg.visited_cylinder <= emit_cyl;
            m_data_reg.step_distance    <= step;
            m_data_reg.total_seek       <= total_sat;
            m_data_reg.last_visit       <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks on the cell row and the sequencer.
    `SDSS_ASSERT_NOW(a_row_sorted, link[0].valid && link[1 % MAX_REQUESTS].valid, link[0].value <= link[1 % MAX_REQUESTS].value, "request row out of order")
    `SDSS_ASSERT_NOW(a_stack_packed, link[1 % MAX_REQUESTS].s_valid, link[0].s_valid, "stack has a hole at its front")
    `SDSS_ASSERT_NOW(a_idle_stack_empty, state_reg == sdss_pkg::ST_IDLE, !link[0].s_valid, "stack not empty while idle")
    `SDSS_ASSERT_NEXT(a_last_drains, emit && emit_last, state_reg == sdss_pkg::ST_IDLE && !link[0].valid && !link[0].s_valid, "schedule ended with requests left")

endmodule

>>> hdl/sdss_cell.sv
// ----------------------------------------------------------------------------
// sdss_cell
// One cell of the request chain: a slot of the sorted request row and a slot
// of the return stack, each trading values with its two neighbors.
// ----------------------------------------------------------------------------
module sdss_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sdss_pkg::cell_ctrl_t           ctrl,
    input  logic [sdss_pkg::CYL_BITS-1:0]  ins_cyl,
    input  sdss_pkg::cell_link_t           left_in,
    input  sdss_pkg::cell_link_t           right_in,
    output sdss_pkg::cell_link_t           link_out
);

    logic                          valid_reg, valid_next;
    logic [sdss_pkg::CYL_BITS-1:0] value_reg, value_next;
    logic                          s_valid_reg, s_valid_next;
    logic [sdss_pkg::CYL_BITS-1:0] s_value_reg, s_value_next;
    logic                          my_gt;

    // This slot holds a value that must move back to make room.
    assign my_gt = valid_reg && (value_reg > ins_cyl);

    // Next contents of both slots.
    always_comb begin
        valid_next   = valid_reg;
        value_next   = value_reg;
        s_valid_next = s_valid_reg;
        s_value_next = s_value_reg;

        if (ctrl.ins) begin
            // Take the left value if it moves back too, otherwise the new one.
            if (my_gt || (!valid_reg && left_in.valid)) begin
                valid_next = 1'b1;
                value_next = left_in.gt ? left_in.value : ins_cyl;
            end
        end else if (ctrl.shift) begin
            valid_next = right_in.valid;
            value_next = right_in.value;
        end

        if (ctrl.push) begin
            s_valid_next = left_in.s_valid;
            s_value_next = left_in.s_value;
        end else if (ctrl.pop) begin
            s_valid_next = right_in.s_valid;
            s_value_next = right_in.s_value;
        end
    end

    // Valid bits reset; the data slots need none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            s_valid_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            s_valid_reg <= s_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        s_value_reg <= s_value_next;
    end

    assign link_out.valid   = valid_reg;
    assign link_out.gt      = my_gt;
    assign link_out.value   = value_reg;
    assign link_out.s_valid = s_valid_reg;
    assign link_out.s_value = s_value_reg;

endmodule
